// ===== hdl/bqlpf_pkg.sv =====
// Shared types, constants and microcode program of the biquad low-pass filter.
package bqlpf_pkg;

   // Fixed formats
   localparam int COEF_WIDTH   = 18;
   localparam int STATE_WIDTH  = 32;
   localparam int STATE_FRAC   = 8;
   localparam int PROD_WIDTH   = COEF_WIDTH + STATE_WIDTH;
   localparam int CSR_INDEX_W  = 3;

   // Coefficient reset values
   localparam logic signed [COEF_WIDTH-1:0] COEF_B0_RESET = 18'sd65536;

   // Configuration register indexes
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_COEF_B0 = 3'd0;
   localparam csr_index_type CSR_COEF_B1 = 3'd1;
   localparam csr_index_type CSR_COEF_B2 = 3'd2;
   localparam csr_index_type CSR_COEF_A1 = 3'd3;
   localparam csr_index_type CSR_COEF_A2 = 3'd4;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } coef_set_type;

   // Accumulator operations
   typedef logic [2:0] acc_op_type;
   localparam acc_op_type ACC_HOLD   = 3'd0;
   localparam acc_op_type ACC_LOAD_X = 3'd1;
   localparam acc_op_type ACC_SUB    = 3'd2;
   localparam acc_op_type ACC_ADD    = 3'd3;
   localparam acc_op_type ACC_CLEAR  = 3'd4;

   // Multiplier coefficient operand
   typedef logic [2:0] coef_sel_type;
   localparam coef_sel_type SEL_A1 = 3'd0;
   localparam coef_sel_type SEL_A2 = 3'd1;
   localparam coef_sel_type SEL_B0 = 3'd2;
   localparam coef_sel_type SEL_B1 = 3'd3;
   localparam coef_sel_type SEL_B2 = 3'd4;

   // Multiplier data operand
   typedef logic [1:0] data_sel_type;
   localparam data_sel_type SEL_D1 = 2'd0;
   localparam data_sel_type SEL_D2 = 2'd1;
   localparam data_sel_type SEL_W  = 2'd2;

   // Branch conditions
   typedef logic [1:0] branch_type;
   localparam branch_type BR_NEXT     = 2'd0;
   localparam branch_type BR_WAIT_REQ = 2'd1;
   localparam branch_type BR_WAIT_OUT = 2'd2;

   // Program steps
   localparam int STEP_W = 3;
   typedef logic [STEP_W-1:0] step_type;
   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_SUB_A1 = 3'd1;
   localparam step_type STEP_SUB_A2 = 3'd2;
   localparam step_type STEP_W_OUT  = 3'd3;
   localparam step_type STEP_ADD_B1 = 3'd4;
   localparam step_type STEP_ADD_B2 = 3'd5;
   localparam step_type STEP_ADD_B0 = 3'd6;
   localparam step_type STEP_Y_OUT  = 3'd7;

   // One control word
   typedef struct packed {
      acc_op_type   acc_op;
      coef_sel_type coef_sel;
      data_sel_type data_sel;
      logic         x_load;
      logic         w_load;
      logic         delay_shift;
      logic         out_load;
      branch_type   branch;
   } ctrl_type;

   // Sequencer status inputs
   typedef struct packed {
      logic req_valid;
      logic out_free;
   } seq_status_type;

   localparam ctrl_type CTRL_NOP = '{
      acc_op:      ACC_HOLD,
      coef_sel:    SEL_A1,
      data_sel:    SEL_D1,
      x_load:      1'b0,
      w_load:      1'b0,
      delay_shift: 1'b0,
      out_load:    1'b0,
      branch:      BR_NEXT
   };

   // Microcode program: feedback sum, round w, feed-forward sum, round y
   function automatic ctrl_type ucode_rom(step_type step);
      ctrl_type w;
      w = CTRL_NOP;
      unique case (step)
         STEP_IDLE: begin
            w.x_load   = 1'b1;
            w.acc_op   = ACC_LOAD_X;
            w.coef_sel = SEL_A1;
            w.data_sel = SEL_D1;
            w.branch   = BR_WAIT_REQ;
         end
         STEP_SUB_A1: begin
            w.acc_op   = ACC_SUB;
            w.coef_sel = SEL_A2;
            w.data_sel = SEL_D2;
         end
         STEP_SUB_A2: begin
            w.acc_op = ACC_SUB;
         end
         STEP_W_OUT: begin
            w.w_load   = 1'b1;
            w.acc_op   = ACC_CLEAR;
            w.coef_sel = SEL_B1;
            w.data_sel = SEL_D1;
         end
         STEP_ADD_B1: begin
            w.acc_op   = ACC_ADD;
            w.coef_sel = SEL_B2;
            w.data_sel = SEL_D2;
         end
         STEP_ADD_B2: begin
            w.acc_op   = ACC_ADD;
            w.coef_sel = SEL_B0;
            w.data_sel = SEL_W;
         end
         STEP_ADD_B0: begin
            w.acc_op      = ACC_ADD;
            w.delay_shift = 1'b1;
         end
         STEP_Y_OUT: begin
            w.out_load = 1'b1;
            w.branch   = BR_WAIT_OUT;
         end
         default: begin
            w = CTRL_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/bqlpf_sequencer.sv =====
// Microcode sequencer: step counter, program ROM and conditional branching.
module bqlpf_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  bqlpf_pkg::seq_status_type status,
   output bqlpf_pkg::ctrl_type      ctrl,
   output logic                     idle
);
   import bqlpf_pkg::*;

   step_type step_ff, step_in;
   ctrl_type rom_word;
   logic     go;

   assign rom_word = ucode_rom(step_ff);
   assign idle     = (step_ff == STEP_IDLE);

   // Branch decision
   always_comb begin
      go      = 1'b1;
      step_in = step_ff;
      unique case (rom_word.branch)
         BR_NEXT: begin
            go      = 1'b1;
            step_in = step_ff + 3'd1;
         end
         BR_WAIT_REQ: begin
            go      = status.req_valid;
            step_in = go ? step_ff + 3'd1 : step_ff;
         end
         BR_WAIT_OUT: begin
            go      = status.out_free;
            step_in = go ? STEP_IDLE : step_ff;
         end
         default: begin
            go      = 1'b0;
            step_in = STEP_IDLE;
         end
      endcase
   end

   // Actions of a waiting step are held off until its condition is met
   always_comb begin
      ctrl = rom_word;
      if (!go) begin
         ctrl.acc_op      = ACC_HOLD;
         ctrl.x_load      = 1'b0;
         ctrl.w_load      = 1'b0;
         ctrl.delay_shift = 1'b0;
         ctrl.out_load    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== hdl/bqlpf_datapath.sv =====
// Datapath: shared multiplier, accumulator, rounding, delay line and saturation.
module bqlpf_datapath #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bqlpf_pkg::ctrl_type            ctrl,
   input  bqlpf_pkg::coef_set_type        coefs,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   output logic signed [SAMPLE_WIDTH-1:0] y_out,
   output logic                           flag_out
);
   import bqlpf_pkg::*;

   localparam int X_TERM_W = SAMPLE_WIDTH + STATE_FRAC + COEF_FRAC_BITS;
   localparam int ACC_W    = ((X_TERM_W > PROD_WIDTH) ? X_TERM_W : PROD_WIDTH) + 2;
   localparam logic signed [ACC_W-1:0] RND_W = ACC_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] RND_Y = ACC_W'(1) << (COEF_FRAC_BITS + STATE_FRAC - 1);
   localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [STATE_WIDTH-1:0]  d1_ff, d2_ff, w_ff, w_in;
   logic                           flag_ff;
   logic signed [COEF_WIDTH-1:0]   coef_mux;
   logic signed [STATE_WIDTH-1:0]  data_mux;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic signed [ACC_W-1:0]        acc_ff, acc_in, acc_x;
   logic signed [ACC_W-1:0]        w_full, y_full;
   logic [ACC_W-STATE_WIDTH:0]     w_hi;
   logic [ACC_W-SAMPLE_WIDTH:0]    y_hi;
   logic                           w_ovf, y_sat;

   // Multiplier operand selection
   always_comb begin
      unique case (ctrl.coef_sel)
         SEL_A1:  coef_mux = coefs.a1;
         SEL_A2:  coef_mux = coefs.a2;
         SEL_B0:  coef_mux = coefs.b0;
         SEL_B1:  coef_mux = coefs.b1;
         SEL_B2:  coef_mux = coefs.b2;
         default: coef_mux = '0;
      endcase
      unique case (ctrl.data_sel)
         SEL_D1:  data_mux = d1_ff;
         SEL_D2:  data_mux = d2_ff;
         SEL_W:   data_mux = w_ff;
         default: data_mux = '0;
      endcase
   end

   // Registered product
   always_ff @(posedge clock) begin
      prod_ff <= coef_mux * data_mux;
   end

   // Accumulator
   assign acc_x = ACC_W'(sample_in) <<< (COEF_FRAC_BITS + STATE_FRAC);

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:   acc_in = acc_ff;
         ACC_LOAD_X: acc_in = acc_x;
         ACC_SUB:    acc_in = acc_ff - ACC_W'(prod_ff);
         ACC_ADD:    acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_CLEAR:  acc_in = '0;
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Round w to the state format; out of range falls back to the scaled sample
   assign w_full = (acc_ff + RND_W) >>> COEF_FRAC_BITS;
   assign w_hi   = w_full[ACC_W-1:STATE_WIDTH-1];
   assign w_ovf  = !((&w_hi) || !(|w_hi));
   assign w_in   = w_ovf ? (STATE_WIDTH'(x_ff) <<< STATE_FRAC)
                         : w_full[STATE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.x_load) begin
         x_ff <= sample_in;
      end
      if (ctrl.w_load) begin
         w_ff    <= w_in;
         flag_ff <= w_ovf;
      end
   end

   // Delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctrl.delay_shift) begin
         d2_ff <= d1_ff;
         d1_ff <= w_ff;
      end
   end

   // Round y to sample units and saturate
   assign y_full = (acc_ff + RND_Y) >>> (COEF_FRAC_BITS + STATE_FRAC);
   assign y_hi   = y_full[ACC_W-1:SAMPLE_WIDTH-1];
   assign y_sat  = !((&y_hi) || !(|y_hi));

   always_comb begin
      priority if (!y_sat) begin
         y_out = y_full[SAMPLE_WIDTH-1:0];
      end else if (y_full[ACC_W-1]) begin
         y_out = Y_MIN;
      end else begin
         y_out = Y_MAX;
      end
   end

   assign flag_out = flag_ff | y_sat;

endmodule

// ===== hdl/biquad_low_pass_filter.sv =====
// Top level of the biquad low-pass filter: registers, sequencer, datapath, result stage.
//
// Second-order direct-form-II IIR low-pass filter with programmable Q2.x coefficients.
// Input channel req_*: one signed sample per transaction (req_valid / req_ready).
// Result channel rsp_*: one filtered sample and an overflow flag per input transaction.
// Configuration: csr_write_en with csr_index (0 b0, 1 b1, 2 b2, 3 a1, 4 a2) and
// csr_wdata; write only while no transaction is in flight. Other indexes are ignored.
// Sequencing: one shared 18x32 multiplier forms the five products serially under the
// microcode program, so an item occupies the accepting step plus 7 steps of feedback
// sum, rounding, feed-forward sum and output rounding. The result is registered, and
// rsp_valid rises when the last step loads it. A new sample is accepted only after
// the previous result has been loaded into the output register.
// A finished result waits in the output register; the next sample is accepted and
// computed meanwhile, and the program holds in its last step only if that register
// is still occupied when the next result is ready.
// Reset: coefficients return to b0 = 65536, all others 0; both delay elements clear;
// no result is pending and req_ready is high in the first cycle after reset.
module biquad_low_pass_filter #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_in,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_filtered_out,
   output logic                                   rsp_overflow_flag,
   // configuration
   input  logic                                   csr_write_en,
   input  logic [bqlpf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic signed [bqlpf_pkg::COEF_WIDTH-1:0] csr_wdata
);
   import bqlpf_pkg::*;

   coef_set_type                   coef_ff;
   ctrl_type                       ctrl;
   seq_status_type                 status;
   logic                           seq_idle;
   logic signed [SAMPLE_WIDTH-1:0] y_value;
   logic                           y_flag;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_filtered_ff;
   logic                           rsp_flag_ff;
   logic                           out_free;

   // Coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= COEF_B0_RESET;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_COEF_B0: coef_ff.b0 <= csr_wdata;
            CSR_COEF_B1: coef_ff.b1 <= csr_wdata;
            CSR_COEF_B2: coef_ff.b2 <= csr_wdata;
            CSR_COEF_A1: coef_ff.a1 <= csr_wdata;
            CSR_COEF_A2: coef_ff.a2 <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Control
   assign out_free         = !rsp_valid_ff || rsp_ready;
   assign status.req_valid = req_valid;
   assign status.out_free  = out_free;

   bqlpf_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .idle   (seq_idle)
   );

   assign req_ready = seq_idle;

   bqlpf_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .coefs     (coef_ff),
      .sample_in (req_sample_in),
      .y_out     (y_value),
      .flag_out  (y_flag)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_filtered_ff <= y_value;
         rsp_flag_ff     <= y_flag;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_out  = rsp_filtered_ff;
   assign rsp_overflow_flag = rsp_flag_ff;

   // Checks
   ap_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sequencer stayed idle after accepting a transaction");

   ap_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |=> req_ready)
      else $error("sequencer did not return to idle after writing a result");

   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   ap_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (ctrl.w_load || ctrl.delay_shift) |-> !req_ready)
      else $error("input ready while a transaction is in flight");

endmodule

// ===== sim/tb_biquad_low_pass_filter.sv =====
// Self-checking testbench for the biquad low-pass filter: bit-exact prediction and scoreboard.
`timescale 1ns / 100ps

module tb_biquad_low_pass_filter;
   import bqlpf_pkg::*;

   localparam int SAMPLE_W  = 16;
   localparam int FRAC_BITS = 16;
   localparam int IDLE_PCT  = 14;
   localparam int PHASE_LEN = 200;
   localparam int HOLD_LEN  = 300;

   localparam longint signed STATE_MAX = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
   localparam longint signed STATE_MIN = -(longint'(1) <<< (STATE_WIDTH - 1));
   localparam longint signed OUT_MAX   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint signed OUT_MIN   = -(longint'(1) <<< (SAMPLE_W - 1));

   localparam int COEF_HI = (1 <<< (COEF_WIDTH - 1)) - 1;
   localparam int COEF_LO = -(1 <<< (COEF_WIDTH - 1));

   typedef logic signed [SAMPLE_W-1:0]   sample_type;
   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   typedef struct {
      sample_type filtered;
      logic       overflow;
   } filter_result_type;

   // Filter predictor and queue of expected filtered samples
   class biquad_scoreboard;
      coef_set_type      coefs;
      longint signed     delay_first;
      longint signed     delay_second;
      filter_result_type expected_q[$];
      int                errors;
      int                samples_noted;

      function new();
         coefs.b0      = COEF_B0_RESET;
         coefs.b1      = '0;
         coefs.b2      = '0;
         coefs.a1      = '0;
         coefs.a2      = '0;
         delay_first   = 0;
         delay_second  = 0;
         errors        = 0;
         samples_noted = 0;
      endfunction

      function void write_coef(csr_index_type index, coef_type value);
         case (index)
            CSR_COEF_B0: coefs.b0 = value;
            CSR_COEF_B1: coefs.b1 = value;
            CSR_COEF_B2: coefs.b2 = value;
            CSR_COEF_A1: coefs.a1 = value;
            CSR_COEF_A2: coefs.a2 = value;
            default: ;  // unknown index is ignored
         endcase
      endfunction

      // Run one sample through the filter and queue the expected output
      function void note_sample(sample_type x);
         longint signed     xs;
         longint signed     acc;
         longint signed     w;
         longint signed     y;
         filter_result_type r;
         r.overflow = 1'b0;
         xs  = longint'(x) <<< STATE_FRAC;
         // feedback sum, round half up into the state format
         acc = (xs <<< FRAC_BITS)
               - longint'($signed(coefs.a1)) * delay_first
               - longint'($signed(coefs.a2)) * delay_second;
         w = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         // state overflow: fall back to the scaled sample
         if (w > STATE_MAX || w < STATE_MIN) begin
            w          = xs;
            r.overflow = 1'b1;
         end
         // feed-forward sum, round half up to sample units
         acc = longint'($signed(coefs.b0)) * w
               + longint'($signed(coefs.b1)) * delay_first
               + longint'($signed(coefs.b2)) * delay_second;
         y = (acc + (longint'(1) <<< (FRAC_BITS + STATE_FRAC - 1))) >>> (FRAC_BITS + STATE_FRAC);
         // output saturation
         if (y > OUT_MAX) begin
            y          = OUT_MAX;
            r.overflow = 1'b1;
         end else if (y < OUT_MIN) begin
            y          = OUT_MIN;
            r.overflow = 1'b1;
         end
         delay_second = delay_first;
         delay_first  = w;
         r.filtered   = y[SAMPLE_W-1:0];
         expected_q.push_back(r);
         samples_noted++;
      endfunction

      function void check_result(sample_type filtered, logic overflow);
         filter_result_type r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result filtered_out=%0d overflow_flag=%0b",
                     $time, filtered, overflow);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         if (filtered !== r.filtered) begin
            $display("%0t: filtered_out mismatch: expected %0d, actual %0d",
                     $time, r.filtered, filtered);
            errors++;
         end
         if (overflow !== r.overflow) begin
            $display("%0t: overflow_flag mismatch: expected %0b, actual %0b",
                     $time, r.overflow, overflow);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   sample_type    req_sample_in;
   logic          rsp_valid;
   logic          rsp_ready;
   sample_type    rsp_filtered_out;
   logic          rsp_overflow_flag;
   logic          csr_write_en;
   csr_index_type csr_index;
   coef_type      csr_wdata;
   bit            steady = 1'b0;  // no idling on either side while set

   biquad_scoreboard sb = new();

   biquad_low_pass_filter #(
      .SAMPLE_WIDTH   (SAMPLE_W),
      .COEF_FRAC_BITS (FRAC_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_in     (req_sample_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_out  (rsp_filtered_out),
      .rsp_overflow_flag (rsp_overflow_flag),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // Offer one sample, with random idle cycles ahead of it
   task automatic send_sample(sample_type x);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(x);
   endtask

   // Write all five coefficients, sometimes followed by a write to an unused index
   task automatic write_coefs(coef_type b0, coef_type b1, coef_type b2, coef_type a1,
                              coef_type a2);
      coef_type      vals[5];
      csr_index_type junk_index;
      coef_type      junk_data;
      vals = '{b0, b1, b2, a1, a2};
      for (int k = CSR_COEF_B0; k <= CSR_COEF_A2; k++) begin
         csr_write_en <= 1'b1;
         csr_index    <= csr_index_type'(k);
         csr_wdata    <= vals[k];
         @(posedge clock);
         sb.write_coef(csr_index_type'(k), vals[k]);
      end
      if ($urandom_range(1) == 1) begin
         junk_index   = csr_index_type'($urandom_range(CSR_COEF_A2 + 1, (1 << CSR_INDEX_W) - 1));
         junk_data    = coef_type'($urandom);
         csr_write_en <= 1'b1;
         csr_index    <= junk_index;
         csr_wdata    <= junk_data;
         @(posedge clock);
         sb.write_coef(junk_index, junk_data);
      end
      csr_write_en <= 1'b0;
   endtask

   // Stop offering and wait until every filtered sample is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic coef_type rand_coef();
      return coef_type'($urandom);
   endfunction

   // Mostly full-range noise, some small signals, some rail values
   function automatic sample_type pick_sample();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70)
         return sample_type'($urandom);
      else if (roll < 85)
         return sample_type'(int'($urandom_range(0, 511)) - 256);
      else if ($urandom_range(1) == 1)
         return sample_type'(OUT_MAX);
      else
         return sample_type'(OUT_MIN);
   endfunction

   // Main stimulus
   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_sample_in <= '0;
      csr_write_en  <= 1'b0;
      csr_index     <= CSR_COEF_B0;
      csr_wdata     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients pass samples through unchanged
      send_sample(sample_type'(0));
      send_sample(sample_type'(OUT_MAX));
      send_sample(sample_type'(OUT_MIN));
      send_sample(sample_type'(1));
      send_sample(sample_type'(-1));
      send_sample(sample_type'(21845));
      drain_results();

      // unstable feedback at the coefficient rails: output saturation, then state overflow
      write_coefs(coef_type'(COEF_HI), coef_type'(COEF_LO), coef_type'(0),
                  coef_type'(COEF_LO), coef_type'(0));
      repeat (10) send_sample(sample_type'(OUT_MAX));
      repeat (6) send_sample(sample_type'(OUT_MIN));
      drain_results();

      // random samples under several coefficient settings
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_coefs(coef_type'(4425), coef_type'(8850), coef_type'(4425),
                           coef_type'(-74907), coef_type'(27054));
            2: write_coefs(coef_type'(COEF_HI), coef_type'(COEF_HI), coef_type'(COEF_HI),
                           coef_type'(COEF_HI), coef_type'(COEF_HI));
            3: write_coefs(coef_type'(COEF_LO), coef_type'(COEF_LO), coef_type'(COEF_LO),
                           coef_type'(COEF_LO), coef_type'(COEF_LO));
            4: write_coefs(coef_type'(19196), coef_type'(38392), coef_type'(19196),
                           coef_type'(0), coef_type'(11247));
            5: write_coefs(rand_coef(), rand_coef(), rand_coef(),
                           coef_type'(int'($urandom_range(0, 65535)) - 32768),
                           coef_type'(int'($urandom_range(0, 65535)) - 32768));
            6: write_coefs(coef_type'(COEF_B0_RESET), coef_type'(0), coef_type'(0),
                           rand_coef(), rand_coef());
            default: write_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                                 rand_coef());
         endcase
         steady = (phase == 4);
         repeat (PHASE_LEN) send_sample(pick_sample());
         drain_results();
      end

      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Result side: random back-pressure plus long hold-offs that fill the block
   initial begin
      int next_hold_at;
      int hold_left;
      next_hold_at = 400;
      hold_left    = 0;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_left == 0 && sb.samples_noted >= next_hold_at) begin
            hold_left    = HOLD_LEN;
            next_hold_at = next_hold_at + 800;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
         @(posedge clock);
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_filtered_out, rsp_overflow_flag);
   end

   // Watchdog
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/bqlpf_pkg.sv
hdl/bqlpf_sequencer.sv
hdl/bqlpf_datapath.sv
hdl/biquad_low_pass_filter.sv
sim/tb_biquad_low_pass_filter.sv
